[sv/iira_pkg.sv]
package iira_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int LEN_W    = 7;
    localparam int WORD_W   = 32;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [LEN_W-1:0]         t_len;

    localparam logic [2:0] ACT_READ       = 3'd0;
    localparam logic [2:0] ACT_WRITE      = 3'd1;
    localparam logic [2:0] ACT_INSERT     = 3'd2;
    localparam logic [2:0] ACT_REMOVE     = 3'd3;
    localparam logic [2:0] ACT_RESIZE     = 3'd4;
    localparam logic [2:0] ACT_CLEAR_SIZE = 3'd5;
    localparam logic [2:0] ACT_ERASE      = 3'd6;

    localparam logic [1:0] ERR_OK     = 2'd0;
    localparam logic [1:0] ERR_INDEX  = 2'd1;
    localparam logic [1:0] ERR_LENGTH = 2'd2;
    localparam logic [1:0] ERR_FULL   = 2'd3;

    localparam t_len CAP_LEN = LEN_W'(CAPACITY);

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_WRITE,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_GROW,
        CELL_ZERO
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_len     pos;
        t_len     count;
        t_len     tlen;
        t_word    value;
    } t_cell_ctl;

endpackage

[sv/iira_cell.sv]
module iira_cell (
    input  logic               i_clk,
    input  iira_pkg::t_len     i_index,
    input  iira_pkg::t_cell_ctl i_ctl,
    input  iira_pkg::t_word    i_lower,
    input  iira_pkg::t_word    i_upper,
    output iira_pkg::t_word    o_data
);
    import iira_pkg::*;

    t_word r_data;
    t_word n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_HOLD: begin
                n_data = r_data;
            end
            CELL_WRITE: begin
                if (i_index == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end
            end
            CELL_INSERT: begin
                if (i_index == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end else if (i_index > i_ctl.pos) begin
                    n_data = i_lower;
                end
            end
            CELL_REMOVE: begin
                if (i_index >= i_ctl.pos) begin
                    n_data = i_upper;
                end
            end
            CELL_GROW: begin
                if (i_index >= i_ctl.count && i_index < i_ctl.tlen) begin
                    n_data = '0;
                end
            end
            CELL_ZERO: begin
                n_data = '0;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[sv/indexed_insert_remove_array.sv]
// Bounded ordered array of signed 32-bit words with a current length.
// Input channel: i_in_valid / o_in_stall carry one request beat (action,
// position, item_value, target_length). Output channel: o_out_valid /
// i_out_stall carry one result beat (read_value, current_length,
// error_code) for every request, in request order.
// The result is registered and appears in the cycle after the request is
// accepted. Throughput: one request per cycle while the receiver does not
// stall. Each word sits in its own cell of a row; insert and remove move
// every word from the position onward by one place in the same cycle.
// A refused request answers with its error code and changes nothing.
// While the receiver stalls, the result register holds its beat and
// o_in_stall rises, so no further request is taken until it is drained.
// Reset (i_rst_n low, synchronous) empties the output register and sets
// the length to zero; stored words are not cleared, and no word beyond
// the length is ever read back.
module indexed_insert_remove_array (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [2:0]            i_action,
    input  logic [6:0]            i_position,
    input  logic signed [31:0]    i_item_value,
    input  logic [6:0]            i_target_length,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [31:0]    o_read_value,
    output logic [6:0]            o_current_length,
    output logic [1:0]            o_error_code
);
    import iira_pkg::*;

    t_word     w_data  [CAPACITY];
    t_word     w_lower [CAPACITY];
    t_word     w_upper [CAPACITY];
    t_cell_ctl w_ctl;

    logic      r_out_valid;
    t_len      r_count;
    t_word     r_read_value;
    logic [1:0] r_error;

    t_len      n_count;
    t_word     n_read_value;
    logic [1:0] n_error;
    t_cell_op  n_op;
    logic      w_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_count      = r_count;
        n_read_value = '0;
        n_error      = ERR_OK;
        n_op         = CELL_HOLD;
        case (i_action)
            ACT_READ: begin
                if (i_position < r_count) begin
                    n_read_value = w_data[i_position[IDX_W-1:0]];
                end else begin
                    n_error = ERR_INDEX;
                end
            end
            ACT_WRITE: begin
                if (i_position < r_count) begin
                    n_op = CELL_WRITE;
                end else begin
                    n_error = ERR_INDEX;
                end
            end
            ACT_INSERT: begin
                if (i_position > r_count) begin
                    n_error = ERR_INDEX;
                end else if (r_count >= CAP_LEN) begin
                    n_error = ERR_FULL;
                end else begin
                    n_op    = CELL_INSERT;
                    n_count = r_count + 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (i_position < r_count) begin
                    n_op    = CELL_REMOVE;
                    n_count = r_count - 1'b1;
                end else begin
                    n_error = ERR_INDEX;
                end
            end
            ACT_RESIZE: begin
                if (i_target_length == '0 || i_target_length > CAP_LEN) begin
                    n_error = ERR_LENGTH;
                end else begin
                    n_op    = CELL_GROW;
                    n_count = i_target_length;
                end
            end
            ACT_CLEAR_SIZE: begin
                if (i_target_length > CAP_LEN) begin
                    n_error = ERR_LENGTH;
                end else begin
                    n_op    = CELL_ZERO;
                    n_count = i_target_length;
                end
            end
            ACT_ERASE: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        w_ctl.op    = w_accept ? n_op : CELL_HOLD;
        w_ctl.pos   = i_position;
        w_ctl.count = r_count;
        w_ctl.tlen  = i_target_length;
        w_ctl.value = i_item_value;
    end

    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            w_lower[k] = (k == 0) ? '0 : w_data[IDX_W'(k - 1)];
            w_upper[k] = (k == CAPACITY - 1) ? '0 : w_data[IDX_W'(k + 1)];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        iira_cell u_cell (
            .i_clk   (i_clk),
            .i_index (LEN_W'(g)),
            .i_ctl   (w_ctl),
            .i_lower (w_lower[g]),
            .i_upper (w_upper[g]),
            .o_data  (w_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
            r_count     <= n_count;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_value <= n_read_value;
            r_error      <= n_error;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_value     = r_read_value;
    assign o_current_length = r_count;
    assign o_error_code     = r_error;

endmodule

[sim/tb.sv]
module tb;
    import iira_pkg::*;

    localparam logic [2:0] ACT_UNUSED      = 3'd7;
    localparam int         RANDOM_REQUESTS = 1324;
    localparam int         REPORT_LIMIT    = 10;
    localparam int         DRAIN_LIMIT     = 5000;

    typedef struct packed {
        t_word      rd;
        t_len       len;
        logic [1:0] err;
    } t_result;

    typedef struct packed {
        logic [2:0] act;
        t_len       pos;
        t_word      val;
        t_len       tlen;
        logic       typed;
        t_result    res;
    } t_request_row;

    localparam t_word WORD_MIN = 32'sh8000_0000;
    localparam t_word WORD_MAX = 32'sh7FFF_FFFF;
    localparam t_word WORD_EXTREMES [4] = '{WORD_MIN, WORD_MAX, 32'sd0, -32'sd1};

    localparam int DIRECTED_ROWS = 26;
    localparam t_request_row DIRECTED_REQUESTS [DIRECTED_ROWS] = '{
        '{ACT_READ,       7'd0,   32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd0,  ERR_INDEX}},
        '{ACT_WRITE,      7'd0,   32'sh1234,     7'd0,   1'b1, '{32'sd0,  7'd0,  ERR_INDEX}},
        '{ACT_INSERT,     7'd1,   32'sd5,        7'd0,   1'b1, '{32'sd0,  7'd0,  ERR_INDEX}},
        '{ACT_RESIZE,     7'd0,   32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd0,  ERR_LENGTH}},
        '{ACT_RESIZE,     7'd0,   32'sd0,        7'd65,  1'b1, '{32'sd0,  7'd0,  ERR_LENGTH}},
        '{ACT_CLEAR_SIZE, 7'd0,   32'sd0,        7'd127, 1'b1, '{32'sd0,  7'd0,  ERR_LENGTH}},
        '{ACT_UNUSED,     7'd127, -32'sd1,       7'd127, 1'b1, '{32'sd0,  7'd0,  ERR_OK}},
        '{ACT_INSERT,     7'd0,   WORD_MAX,      7'd0,   1'b1, '{32'sd0,  7'd1,  ERR_OK}},
        '{ACT_INSERT,     7'd0,   WORD_MIN,      7'd0,   1'b1, '{32'sd0,  7'd2,  ERR_OK}},
        '{ACT_INSERT,     7'd2,   -32'sd1,       7'd0,   1'b1, '{32'sd0,  7'd3,  ERR_OK}},
        '{ACT_READ,       7'd0,   32'sd0,        7'd0,   1'b1, '{WORD_MIN, 7'd3, ERR_OK}},
        '{ACT_READ,       7'd2,   32'sd0,        7'd0,   1'b1, '{-32'sd1, 7'd3,  ERR_OK}},
        '{ACT_WRITE,      7'd1,   32'sh5555_5555, 7'd0,  1'b0, '{32'sd0,  7'd0,  ERR_OK}},
        '{ACT_INSERT,     7'd1,   32'shAAAA_AAAA, 7'd0,  1'b0, '{32'sd0,  7'd0,  ERR_OK}},
        '{ACT_REMOVE,     7'd0,   32'sd0,        7'd0,   1'b0, '{32'sd0,  7'd0,  ERR_OK}},
        '{ACT_READ,       7'd0,   32'sd0,        7'd0,   1'b0, '{32'sd0,  7'd0,  ERR_OK}},
        '{ACT_RESIZE,     7'd0,   32'sd0,        7'd64,  1'b1, '{32'sd0,  7'd64, ERR_OK}},
        '{ACT_READ,       7'd63,  32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd64, ERR_OK}},
        '{ACT_INSERT,     7'd10,  32'sd7,        7'd0,   1'b1, '{32'sd0,  7'd64, ERR_FULL}},
        '{ACT_INSERT,     7'd65,  32'sd7,        7'd0,   1'b1, '{32'sd0,  7'd64, ERR_INDEX}},
        '{ACT_RESIZE,     7'd0,   32'sd0,        7'd64,  1'b1, '{32'sd0,  7'd64, ERR_OK}},
        '{ACT_REMOVE,     7'd63,  32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd63, ERR_OK}},
        '{ACT_READ,       7'd64,  32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd63, ERR_INDEX}},
        '{ACT_CLEAR_SIZE, 7'd0,   32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd0,  ERR_OK}},
        '{ACT_RESIZE,     7'd0,   32'sd0,        7'd3,   1'b1, '{32'sd0,  7'd3,  ERR_OK}},
        '{ACT_ERASE,      7'd0,   32'sd0,        7'd0,   1'b1, '{32'sd0,  7'd0,  ERR_OK}}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_action = ACT_READ;
    t_len        i_position = '0;
    t_word       i_item_value = '0;
    t_len        i_target_length = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_word       o_read_value;
    t_len        o_current_length;
    logic [1:0]  o_error_code;

    indexed_insert_remove_array dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_position       (i_position),
        .i_item_value     (i_item_value),
        .i_target_length  (i_target_length),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_read_value     (o_read_value),
        .o_current_length (o_current_length),
        .o_error_code     (o_error_code)
    );

    t_word   array_words [CAPACITY];
    int      array_len;
    t_result pending_results [$];
    t_result oldest_result;
    int      mismatches;
    int      results_checked;
    int      refusals [4];
    int      peak_len;
    int      stall_mode;
    int      stall_phase_left;
    int      stall_tick;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #400000;
        $display("Timeout with %0d results still pending", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_result apply_request(logic [2:0] act, t_len pos, t_word val,
                                              t_len tlen);
        t_result r;
        int      p;
        int      t;
        r = '0;
        r.err = ERR_OK;
        p = pos;
        t = tlen;
        case (act)
            ACT_READ: begin
                if (p < array_len) r.rd = array_words[p];
                else r.err = ERR_INDEX;
            end
            ACT_WRITE: begin
                if (p < array_len) array_words[p] = val;
                else r.err = ERR_INDEX;
            end
            ACT_INSERT: begin
                if (p > array_len) begin
                    r.err = ERR_INDEX;
                end else if (array_len >= CAPACITY) begin
                    r.err = ERR_FULL;
                end else begin
                    for (int i = array_len; i > p; i--) array_words[i] = array_words[i-1];
                    array_words[p] = val;
                    array_len++;
                end
            end
            ACT_REMOVE: begin
                if (p < array_len) begin
                    for (int i = p; i + 1 < array_len; i++) array_words[i] = array_words[i+1];
                    array_len--;
                end else begin
                    r.err = ERR_INDEX;
                end
            end
            ACT_RESIZE: begin
                if (t == 0 || t > CAPACITY) begin
                    r.err = ERR_LENGTH;
                end else begin
                    for (int i = array_len; i < t; i++) array_words[i] = '0;
                    array_len = t;
                end
            end
            ACT_CLEAR_SIZE: begin
                if (t > CAPACITY) begin
                    r.err = ERR_LENGTH;
                end else begin
                    for (int i = 0; i < CAPACITY; i++) array_words[i] = '0;
                    array_len = t;
                end
            end
            ACT_ERASE: array_len = 0;
            default: ;
        endcase
        r.len = t_len'(array_len);
        return r;
    endfunction

    // receiver: quiet, random and periodic stall phases
    always @(posedge i_clk) begin
        if (stall_phase_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_phase_left = $urandom_range(20, 150);
        end
        stall_phase_left--;
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 40);
            default: i_out_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result beat: read_value %0d length %0d error %0d",
                             o_read_value, o_current_length, o_error_code);
            end else begin
                oldest_result = pending_results.pop_front();
                results_checked++;
                if (o_read_value !== oldest_result.rd ||
                    o_current_length !== oldest_result.len ||
                    o_error_code !== oldest_result.err) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("Mismatch on result %0d: read_value exp %0d got %0d",
                                 results_checked, oldest_result.rd, o_read_value);
                        $display("    length exp %0d got %0d, error exp %0d got %0d",
                                 oldest_result.len, o_current_length,
                                 oldest_result.err, o_error_code);
                    end
                end
            end
        end
    end

    initial begin
        t_request_row row;
        t_result      predicted;
        int           burst_left;
        int           gap;
        int           pick;
        int           insert_hi;
        int           remove_hi;
        int           drain_wait;
        bit           grow_bias;

        for (int i = 0; i < CAPACITY; i++) array_words[i] = '0;
        array_len = 0;
        burst_left = 0;
        grow_bias = 1'b1;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ROWS + RANDOM_REQUESTS; k++) begin
            if (k < DIRECTED_ROWS) begin
                row = DIRECTED_REQUESTS[k];
            end else begin
                row = '0;
                if ($urandom_range(0, 39) == 0) grow_bias = !grow_bias;
                insert_hi = grow_bias ? 64 : 44;
                remove_hi = grow_bias ? 76 : 74;
                pick = $urandom_range(0, 99);
                if (pick < 22)             row.act = ACT_READ;
                else if (pick < 34)        row.act = ACT_WRITE;
                else if (pick < insert_hi) row.act = ACT_INSERT;
                else if (pick < remove_hi) row.act = ACT_REMOVE;
                else if (pick < 86)        row.act = ACT_RESIZE;
                else if (pick < 90)        row.act = ACT_CLEAR_SIZE;
                else if (pick < 92)        row.act = ACT_ERASE;
                else if (pick < 98)        row.act = ACT_READ;
                else                       row.act = ACT_UNUSED;
                if ($urandom_range(0, 9) < 8) row.pos = t_len'($urandom_range(0, array_len));
                else row.pos = t_len'($urandom_range(0, 127));
                if ($urandom_range(0, 9) == 0) row.val = WORD_EXTREMES[$urandom_range(0, 3)];
                else row.val = $urandom;
                pick = $urandom_range(0, 9);
                if (pick < 6)       row.tlen = t_len'($urandom_range(0, CAPACITY));
                else if (pick < 8)  row.tlen = t_len'(CAPACITY - $urandom_range(0, 1));
                else if (pick == 8) row.tlen = t_len'($urandom_range(0, 4));
                else                row.tlen = t_len'($urandom_range(0, 127));
            end

            // hold off between bursts
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                burst_left = $urandom_range(1, 30);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;

            i_in_valid      <= 1'b1;
            i_action        <= row.act;
            i_position      <= row.pos;
            i_item_value    <= row.val;
            i_target_length <= row.tlen;
            do @(posedge i_clk); while (o_in_stall);

            predicted = apply_request(row.act, row.pos, row.val, row.tlen);
            pending_results.push_back(row.typed ? row.res : predicted);
            refusals[predicted.err]++;
            if (array_len > peak_len) peak_len = array_len;
        end
        i_in_valid <= 1'b0;

        drain_wait = 0;
        while (pending_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d expected results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("Sent %0d requests (%0d directed), checked %0d results, longest array %0d of %0d",
                 DIRECTED_ROWS + RANDOM_REQUESTS, DIRECTED_ROWS, results_checked,
                 peak_len, CAPACITY);
        $display("Refused requests: bad index %0d, bad length %0d, array full %0d",
                 refusals[ERR_INDEX], refusals[ERR_LENGTH], refusals[ERR_FULL]);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
